FILE: hw/rtl/pmvi_pkg.sv
// Shared types, constants and helpers for the point-mass velocity integrator.
// Used by pmvi_div and point_mass_velocity_integrator; depends on nothing.
package pmvi_pkg;

  // Field and datapath widths
  localparam int VEL_W     = 32;            // velocity and pending force, Q16.16
  localparam int WEIGHT_W  = 31;            // mass_weight and body_volume
  localparam int FORCE_W   = 36;            // exact total force per axis
  localparam int ACC_W     = 36;            // signed acceleration from the divider
  localparam int SUM_W     = ACC_W + 1;     // velocity plus acceleration
  localparam int Q_W       = 34;            // quotient bits developed by the divider
  localparam int CNT_W     = 6;             // divider step counter
  localparam int MUL_A_W   = 33;            // multiplier operand A (signed)
  localparam int MUL_B_W   = 18;            // multiplier operand B (signed coefficient)
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int FRAC_W    = 16;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam int CFG_IDX_W = 2;

  // Q16.16 coefficients
  localparam logic signed [MUL_B_W-1:0] BUOYANCY_Q    = -18'sd34079;
  localparam logic signed [MUL_B_W-1:0] DRAG_WATER_Q  = 18'sd1966;
  localparam logic signed [MUL_B_W-1:0] DRAG_GROUND_Q = 18'sd3277;
  localparam logic signed [MUL_B_W-1:0] DRAG_AIR_Q    = 18'sd7;
  localparam logic signed [PROD_W-1:0]  ROUND_HALF    = PROD_W'(32768);

  // Saturation limits on the acceleration / sum width
  localparam logic signed [ACC_W-1:0] ACC_POS_MAX = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] ACC_NEG_MAX = -ACC_W'(64'sh80000000);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MASS_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_ON    = 2'd2;

  // Input commands
  typedef enum logic [1:0] {
    CMD_ADD_FORCE = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_SET_ENV   = 2'd2,
    CMD_INV_ENV   = 2'd3
  } cmd_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFFFFFF);
    lo = -SUM_W'(64'sh80000000);
    if (x > hi) begin
      sat_vel = hi[VEL_W-1:0];
    end else if (x < lo) begin
      sat_vel = lo[VEL_W-1:0];
    end else begin
      sat_vel = x[VEL_W-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/point_mass_velocity_integrator.sv
// Non-tick transactions: result valid the cycle after acceptance, one per cycle while out_ready holds.
// Tick transactions: no new input is accepted until the sequencer is back in S_IDLE: one shared
// 33x18 multiplier does three multiply/accumulate pairs, the shared divider then handles
// each axis, x then y, and S_DONE publishes the result; zero weight or an oversized
// quotient skips the division steps. Ready drops while busy or a result waits.
// Synchronous active-low reset clears velocity, pending force and mode, loads defaults.
module point_mass_velocity_integrator import pmvi_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic signed [VEL_W-1:0]     in_force_x,
  input  logic signed [VEL_W-1:0]     in_force_y,
  input  logic                        in_grounded,
  input  logic                        in_environment,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [VEL_W-1:0]     out_velocity_x,
  output logic signed [VEL_W-1:0]     out_velocity_y,
  output logic                        out_mode_now,
  // configuration port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [WEIGHT_W-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    T_BUOY,
    T_DRAG_X,
    T_DRAG_Y
  } term_t;

  state_t                       state_r;
  term_t                        term_r;

  logic [WEIGHT_W-1:0]          mass_weight_r;
  logic [WEIGHT_W-1:0]          body_volume_r;
  logic                         const_on_r;

  logic signed [VEL_W-1:0]      vel_x_r;
  logic signed [VEL_W-1:0]      vel_y_r;
  logic signed [VEL_W-1:0]      pending_x_r;
  logic signed [VEL_W-1:0]      pending_y_r;
  logic                         env_mode_r;

  logic signed [FORCE_W-1:0]    fx_r;
  logic signed [FORCE_W-1:0]    fy_r;
  logic signed [MUL_B_W-1:0]    drag_c_r;
  logic signed [PROD_W-1:0]     prod_r;

  logic                         out_valid_r;
  logic signed [VEL_W-1:0]      out_vx_r;
  logic signed [VEL_W-1:0]      out_vy_r;
  logic                         out_mode_r;

  cmd_t                         cmd;
  logic                         in_fire;
  logic [WEIGHT_W-1:0]          gravity;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [PROD_W-1:0]     rnd_sum;
  logic signed [FORCE_W-1:0]    rnd_term;
  logic signed [SUM_W-1:0]      pend_sum_x;
  logic signed [SUM_W-1:0]      pend_sum_y;
  logic signed [SUM_W-1:0]      vel_sum;
  logic                         div_start;
  logic signed [FORCE_W-1:0]    div_force;
  logic                         div_done;
  logic signed [ACC_W-1:0]      div_acc;

  assign cmd      = cmd_t'(in_command);
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Gravity term: weight * 0.5 rounded half up
  assign gravity = WEIGHT_W'(({1'b0, mass_weight_r} + 1'b1) >> 1);

  // Shared multiplier operand selection
  always_comb begin
    case (term_r)
      T_BUOY: begin
        mul_a = {2'b00, body_volume_r};
        mul_b = BUOYANCY_Q;
      end
      T_DRAG_X: begin
        mul_a = MUL_A_W'(0) - {vel_x_r[VEL_W-1], vel_x_r};
        mul_b = drag_c_r;
      end
      T_DRAG_Y: begin
        mul_a = MUL_A_W'(0) - {vel_y_r[VEL_W-1], vel_y_r};
        mul_b = drag_c_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round the registered product back to Q16.16
  assign rnd_sum  = prod_r + ROUND_HALF;
  assign rnd_term = {{(FORCE_W - RND_W){rnd_sum[PROD_W-1]}}, rnd_sum[PROD_W-1:FRAC_W]};

  // Saturating pending-force sums
  assign pend_sum_x = SUM_W'(pending_x_r) + SUM_W'(in_force_x);
  assign pend_sum_y = SUM_W'(pending_y_r) + SUM_W'(in_force_y);

  // Divider feed and velocity update
  assign div_start = (state_r == S_DIVX_GO) || (state_r == S_DIVY_GO);
  assign div_force = (state_r == S_DIVY_GO) ? fy_r : fx_r;
  assign vel_sum   = (state_r == S_DIVY_WAIT) ? (SUM_W'(vel_y_r) + SUM_W'(div_acc))
                                              : (SUM_W'(vel_x_r) + SUM_W'(div_acc));

  pmvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .force_in (div_force),
    .weight   (mass_weight_r),
    .done     (div_done),
    .acc      (div_acc)
  );

  // Sequencer, architectural state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      term_r        <= T_BUOY;
      mass_weight_r <= WEIGHT_W'(65536);
      body_volume_r <= WEIGHT_W'(65536);
      const_on_r    <= 1'b1;
      vel_x_r       <= '0;
      vel_y_r       <= '0;
      pending_x_r   <= '0;
      pending_y_r   <= '0;
      env_mode_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MASS_WEIGHT: mass_weight_r <= cfg_wdata;
          CFG_BODY_VOLUME: body_volume_r <= cfg_wdata;
          CFG_CONST_ON:    const_on_r    <= cfg_wdata[0];
          default: ;
        endcase
      end

      // drop the result once taken
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (cmd)
              CMD_ADD_FORCE: begin
                pending_x_r <= sat_vel(pend_sum_x);
                pending_y_r <= sat_vel(pend_sum_y);
                out_valid_r <= 1'b1;
                out_vx_r    <= vel_x_r;
                out_vy_r    <= vel_y_r;
                out_mode_r  <= env_mode_r;
              end
              CMD_TICK: begin
                fx_r <= FORCE_W'(pending_x_r);
                fy_r <= FORCE_W'(pending_y_r) +
                        (const_on_r ? FORCE_W'(gravity) : FORCE_W'(0));
                if (!env_mode_r) begin
                  drag_c_r <= DRAG_WATER_Q;
                end else if (in_grounded) begin
                  drag_c_r <= DRAG_GROUND_Q;
                end else begin
                  drag_c_r <= DRAG_AIR_Q;
                end
                term_r  <= T_BUOY;
                state_r <= S_MUL;
              end
              CMD_SET_ENV: begin
                env_mode_r  <= in_environment;
                out_valid_r <= 1'b1;
                out_vx_r    <= vel_x_r;
                out_vy_r    <= vel_y_r;
                out_mode_r  <= in_environment;
              end
              CMD_INV_ENV: begin
                env_mode_r  <= !env_mode_r;
                out_valid_r <= 1'b1;
                out_vx_r    <= vel_x_r;
                out_vy_r    <= vel_y_r;
                out_mode_r  <= !env_mode_r;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_ADD;
        end
        S_ADD: begin
          // accumulate the rounded term into its axis (buoyancy only with constants on, in water)
          case (term_r)
            T_BUOY: begin
              if (const_on_r && !env_mode_r) begin
                fy_r <= fy_r + rnd_term;
              end
              term_r  <= T_DRAG_X;
              state_r <= S_MUL;
            end
            T_DRAG_X: begin
              fx_r    <= fx_r + rnd_term;
              term_r  <= T_DRAG_Y;
              state_r <= S_MUL;
            end
            default: begin
              fy_r    <= fy_r + rnd_term;
              state_r <= S_DIVX_GO;
            end
          endcase
        end
        S_DIVX_GO: begin
          state_r <= S_DIVX_WAIT;
        end
        S_DIVX_WAIT: begin
          if (div_done) begin
            vel_x_r <= sat_vel(vel_sum);
            state_r <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: begin
          state_r <= S_DIVY_WAIT;
        end
        S_DIVY_WAIT: begin
          if (div_done) begin
            vel_y_r <= sat_vel(vel_sum);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // publish, clear the accumulator
          pending_x_r <= '0;
          pending_y_r <= '0;
          out_valid_r <= 1'b1;
          out_vx_r    <= vel_x_r;
          out_vy_r    <= vel_y_r;
          out_mode_r  <= env_mode_r;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_velocity_x = out_vx_r;
  assign out_velocity_y = out_vy_r;
  assign out_mode_now   = out_mode_r;

`ifndef SYNTH
  a_done_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !out_valid_r)
    else $error("tick result would overwrite a waiting result");
  a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (pending_x_r == '0) && (pending_y_r == '0))
    else $error("pending force not cleared after tick");
  a_vel_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> $stable(vel_x_r) && $stable(vel_y_r))
    else $error("velocity changed outside a tick");
  a_div_only_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX_WAIT) || (state_r == S_DIVY_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

FILE: hw/rtl/pmvi_div.sv
// Iterative restoring divider: acceleration = (force * 2^16) / weight,
// truncated toward zero, one quotient bit per cycle. Depends on pmvi_pkg.
module pmvi_div import pmvi_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [FORCE_W-1:0]  force_in,
  input  logic        [WEIGHT_W-1:0] weight,
  output logic                       done,
  output logic signed [ACC_W-1:0]    acc
);

  logic                    busy_r;
  logic                    done_r;
  logic                    neg_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [WEIGHT_W-1:0]     rem_r;
  logic [Q_W-1:0]          dvd_r;
  logic [Q_W-1:0]          quo_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [FORCE_W-1:0]      mag;
  logic                    too_big;
  logic [WEIGHT_W:0]       trial;
  logic                    fits;
  logic [WEIGHT_W-1:0]     rem_nxt;
  logic [Q_W-1:0]          quo_nxt;
  logic [ACC_W-1:0]        quo_ext;

  // Magnitude of the dividend and the quotient-overflow check
  assign mag     = force_in[FORCE_W-1] ? FORCE_W'(-force_in) : FORCE_W'(force_in);
  assign too_big = {(WEIGHT_W + 18 - FORCE_W)'(0), mag} >= {weight, 18'd0};

  // One restoring step: shift in a dividend bit, subtract when it fits
  assign trial   = {rem_r, dvd_r[Q_W-1]};
  assign fits    = trial >= {1'b0, weight};
  assign rem_nxt = fits ? WEIGHT_W'(trial - {1'b0, weight}) : trial[WEIGHT_W-1:0];
  assign quo_nxt = {quo_r[Q_W-2:0], fits};
  assign quo_ext = {(ACC_W - Q_W)'(0), quo_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r <= force_in[FORCE_W-1];
        if (weight == '0) begin
          // zero weight: the signed 32-bit limit with the force's sign, zero for zero force
          done_r <= 1'b1;
          if (force_in > 0) begin
            acc_r <= ACC_POS_MAX;
          end else if (force_in < 0) begin
            acc_r <= ACC_NEG_MAX;
          end else begin
            acc_r <= '0;
          end
        end else if (too_big) begin
          // quotient beyond the counted bits: clamp, the velocity saturates anyway
          done_r <= 1'b1;
          acc_r  <= force_in[FORCE_W-1] ? -ACC_W'({Q_W{1'b1}}) : ACC_W'({Q_W{1'b1}});
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= WEIGHT_W'(mag[FORCE_W-1:18]);
          dvd_r  <= {mag[17:0], 16'd0};
          quo_r  <= '0;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[Q_W-2:0], 1'b0};
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          acc_r  <= neg_r ? -quo_ext : quo_ext;
        end
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r < CNT_W'(Q_W)))
    else $error("divider step count out of range");
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");
`endif

endmodule
